FILE: rtl/variable_length_message_ring_writer_defines.svh
// Assertion shorthands for the ring writer checker.
`ifndef VARIABLE_LENGTH_MESSAGE_RING_WRITER_DEFINES_SVH
`define VARIABLE_LENGTH_MESSAGE_RING_WRITER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define VLMRW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define VLMRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define VLMRW_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vlmrw_pkg.sv
package vlmrw_pkg;

  localparam int RING_BYTES          = 4096;
  localparam int MAX_MSG_BYTES       = 1024;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam int PTR_W  = 13;
  localparam int ADDR_W = 12;
  localparam int LEN_W  = 13;
  localparam int DATA_W = 32;
  localparam int WL_W   = $clog2(MAX_MSG_BYTES / 4 + 1);

  // command codes on the request channel
  localparam logic [1:0] CMD_BEGIN   = 2'd0;
  localparam logic [1:0] CMD_DATA    = 2'd1;
  localparam logic [1:0] CMD_CONSUME = 2'd2;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_TOO_LONG   = 3'd1,
    STATUS_EMPTY      = 3'd2,
    STATUS_BAD_LENGTH = 3'd3,
    STATUS_NO_SPACE   = 3'd4,
    STATUS_OUT_OF_SEQ = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_DATA,
    OP_CONSUME,
    OP_REJECT
  } op_t;

  // classified request, front to back
  typedef struct packed {
    op_t               op;
    status_t           err;     // reject code
    logic [LEN_W-1:0]  padded;  // length rounded up to words
    logic [LEN_W-1:0]  need;    // padded + header + terminator
    logic [1:0]        tail;    // valid bytes in last word, 0 = all
    logic [DATA_W-1:0] data;    // data word, or length for the header
  } queue_entry_t;

  typedef struct packed {
    status_t           status;
    logic              wr_valid;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [PTR_W-1:0]  rd_ptr_out;
    logic [PTR_W-1:0]  wr_ptr_out;
    logic              last;
  } result_t;

endpackage

FILE: rtl/vlmrw_if.sv
interface vlmrw_req_if import vlmrw_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic signed [LEN_W-1:0] msg_length;
  logic [DATA_W-1:0]       data_word;

  modport source (output valid, cmd, msg_length, data_word, input ready);
  modport sink (input valid, cmd, msg_length, data_word, output ready);
endinterface

interface vlmrw_res_if import vlmrw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic              wr_valid;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [PTR_W-1:0]  rd_ptr_out;
  logic [PTR_W-1:0]  wr_ptr_out;
  logic              last;

  modport source (output valid, status, wr_valid, wr_addr, wr_data, rd_ptr_out, wr_ptr_out,
                  last, input ready);
  modport sink (input valid, status, wr_valid, wr_addr, wr_data, rd_ptr_out, wr_ptr_out,
                last, output ready);
endinterface

FILE: rtl/vlmrw_fifo.sv
module vlmrw_fifo import vlmrw_pkg::*; #(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  queue_entry_t push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output queue_entry_t pop_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_entry_t     slots [DEPTH];
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;
  assign pop_data   = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == IDX_W'(DEPTH - 1)) ? '0 : wr_idx + 1'b1;
      end
      if (pop) begin
        rd_idx <= (rd_idx == IDX_W'(DEPTH - 1)) ? '0 : rd_idx + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_data;
    end
  end

endmodule

FILE: rtl/vlmrw_front.sv
module vlmrw_front import vlmrw_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  vlmrw_req_if.sink     req,
  output queue_entry_t  entry,
  output logic          entry_valid,
  input  logic          entry_pop
);

  localparam logic signed [LEN_W:0] MAX_LEN = (LEN_W + 1)'(MAX_MSG_BYTES);

  logic signed [LEN_W:0] len_ext;
  logic [LEN_W-1:0]      ulen;
  logic [LEN_W-1:0]      padded;
  queue_entry_t          cls;

  assign len_ext = {req.msg_length[LEN_W-1], req.msg_length};
  assign ulen    = req.msg_length;
  assign padded  = (ulen + LEN_W'(3)) & ~LEN_W'(3);

  // length checks in priority order: too long, empty, negative
  always_comb begin
    cls        = '0;
    cls.op     = OP_REJECT;
    cls.err    = STATUS_OUT_OF_SEQ;
    cls.padded = padded;
    cls.need   = padded + LEN_W'(8);
    cls.tail   = ulen[1:0];
    cls.data   = req.data_word;
    unique case (req.cmd)
      CMD_BEGIN: begin
        cls.data = DATA_W'(ulen);
        priority if (len_ext > MAX_LEN) begin
          cls.err = STATUS_TOO_LONG;
        end else if (len_ext == '0) begin
          cls.err = STATUS_EMPTY;
        end else if (len_ext[LEN_W]) begin
          cls.err = STATUS_BAD_LENGTH;
        end else begin
          cls.op = OP_BEGIN;
        end
      end
      CMD_DATA:    cls.op = OP_DATA;
      CMD_CONSUME: cls.op = OP_CONSUME;
      default:     cls.op = OP_REJECT;
    endcase
  end

  vlmrw_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(req.valid),
    .push_ready(req.ready),
    .push_data (cls),
    .pop_valid (entry_valid),
    .pop_ready (entry_pop),
    .pop_data  (entry)
  );

endmodule

FILE: rtl/vlmrw_back.sv
module vlmrw_back import vlmrw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  queue_entry_t entry,
  input  logic         entry_valid,
  output logic         entry_pop,
  vlmrw_res_if.source  res
);

  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic              msg_open, msg_open_next;
  logic [PTR_W-1:0]  cursor, cursor_next;
  logic [WL_W-1:0]   words_left, words_left_next;
  logic [PTR_W-1:0]  commit_ptr, commit_ptr_next;
  logic [1:0]        tail_bytes, tail_bytes_next;
  logic              term_pending, term_pending_next;
  logic              out_valid;
  result_t           out_q, out_next;
  logic              load;

  logic [PTR_W:0]    rp_ext, wp_ext, need_ext;
  logic              place_ok;
  logic [PTR_W-1:0]  place;

  function automatic logic [DATA_W-1:0] tail_mask(input logic [1:0] tail);
    logic [DATA_W-1:0] m;
    unique case (tail)
      2'd1:    m = DATA_W'(32'h0000_00FF);
      2'd2:    m = DATA_W'(32'h0000_FFFF);
      2'd3:    m = DATA_W'(32'h00FF_FFFF);
      default: m = '1;
    endcase
    return m;
  endfunction

  assign rp_ext   = {1'b0, rd_ptr};
  assign wp_ext   = {1'b0, wr_ptr};
  assign need_ext = (PTR_W + 1)'(entry.need);

  // placement: before the reader if it leads, else after the write pointer, else wrapped
  always_comb begin
    place_ok = 1'b0;
    place    = wr_ptr;
    priority if (rd_ptr > wr_ptr) begin
      place_ok = (rp_ext - wp_ext) > need_ext;
    end else if (wp_ext <= (PTR_W + 1)'(RING_BYTES) &&
                 ((PTR_W + 1)'(RING_BYTES) - wp_ext) > need_ext) begin
      place_ok = 1'b1;
    end else begin
      place_ok = rp_ext > need_ext;
      place    = '0;
    end
  end

  always_comb begin
    rd_ptr_next       = rd_ptr;
    wr_ptr_next       = wr_ptr;
    msg_open_next     = msg_open;
    cursor_next       = cursor;
    words_left_next   = words_left;
    commit_ptr_next   = commit_ptr;
    tail_bytes_next   = tail_bytes;
    term_pending_next = term_pending;
    out_next          = '0;
    out_next.status   = STATUS_OK;
    out_next.last     = 1'b1;
    load              = 1'b0;
    entry_pop         = 1'b0;
    if (!out_valid || res.ready) begin
      if (term_pending) begin
        // zero terminator after the final data word
        load              = 1'b1;
        term_pending_next = 1'b0;
        out_next.wr_valid = 1'b1;
        out_next.wr_addr  = commit_ptr[ADDR_W-1:0];
      end else if (entry_valid) begin
        load      = 1'b1;
        entry_pop = 1'b1;
        unique case (entry.op)
          OP_BEGIN: begin
            if (place_ok) begin
              msg_open_next     = 1'b1;
              cursor_next       = place + PTR_W'(4);
              words_left_next   = WL_W'(entry.padded >> 2);
              commit_ptr_next   = place + PTR_W'(4) + PTR_W'(entry.padded);
              tail_bytes_next   = entry.tail;
              out_next.wr_valid = 1'b1;
              out_next.wr_addr  = place[ADDR_W-1:0];
              out_next.wr_data  = entry.data;
            end else begin
              out_next.status = STATUS_NO_SPACE;
            end
          end
          OP_DATA: begin
            if (!msg_open || words_left == '0) begin
              out_next.status = STATUS_OUT_OF_SEQ;
            end else begin
              cursor_next       = cursor + PTR_W'(4);
              words_left_next   = words_left - WL_W'(1);
              out_next.wr_valid = 1'b1;
              out_next.wr_addr  = cursor[ADDR_W-1:0];
              out_next.wr_data  = entry.data;
              if (words_left == WL_W'(1)) begin
                out_next.wr_data  = entry.data & tail_mask(tail_bytes);
                out_next.last     = 1'b0;
                wr_ptr_next       = commit_ptr;
                msg_open_next     = 1'b0;
                term_pending_next = 1'b1;
              end
            end
          end
          OP_CONSUME: begin
            out_next.rd_ptr_out = rd_ptr;
            out_next.wr_ptr_out = wr_ptr;
            rd_ptr_next         = wr_ptr;
          end
          default: begin
            out_next.status = entry.err;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      msg_open     <= 1'b0;
      cursor       <= '0;
      words_left   <= '0;
      commit_ptr   <= '0;
      tail_bytes   <= '0;
      term_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      rd_ptr       <= rd_ptr_next;
      wr_ptr       <= wr_ptr_next;
      msg_open     <= msg_open_next;
      cursor       <= cursor_next;
      words_left   <= words_left_next;
      commit_ptr   <= commit_ptr_next;
      tail_bytes   <= tail_bytes_next;
      term_pending <= term_pending_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= out_next;
    end
  end

  assign res.valid      = out_valid;
  assign res.status     = out_q.status;
  assign res.wr_valid   = out_q.wr_valid;
  assign res.wr_addr    = out_q.wr_addr;
  assign res.wr_data    = out_q.wr_data;
  assign res.rd_ptr_out = out_q.rd_ptr_out;
  assign res.wr_ptr_out = out_q.wr_ptr_out;
  assign res.last       = out_q.last;

endmodule

FILE: rtl/variable_length_message_ring_writer.sv
// Writer side of a byte ring of length-prefixed messages.
// req channel: cmd 0 opens a message of msg_length bytes, cmd 1 delivers one
//   four-byte data_word (earliest byte low), cmd 2 publishes both pointers and
//   hands everything committed to the reader.
// res channel: one result per request, two for the final data word of a
//   message (the word itself, then the zero terminator); last marks the end.
// A request passes through the queue and then the output register before its
//   result is valid. Throughput: one request per cycle while res.ready stays
//   high; a message's final data word holds the back end for the terminator.
// The front end classifies each request (length checks, padding) and drops it
//   into a small queue; the back end owns the ring pointers, does the room
//   test and fills a single output register. req.ready drops only when the
//   queue is full, so a stalled receiver backs up QUEUE_DEPTH requests plus
//   the held result before req stalls.
// Reset (synchronous, rst high): both pointers return to ring start, any
//   open message is dropped, the queue and output register are emptied.
module variable_length_message_ring_writer import vlmrw_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  vlmrw_req_if.sink   req,
  vlmrw_res_if.source res
);

  queue_entry_t entry;
  logic         entry_valid;
  logic         entry_pop;

  // classify and queue
  vlmrw_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .entry      (entry),
    .entry_valid(entry_valid),
    .entry_pop  (entry_pop)
  );

  // ring state, placement and result generation
  vlmrw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .entry      (entry),
    .entry_valid(entry_valid),
    .entry_pop  (entry_pop),
    .res        (res)
  );

endmodule

FILE: rtl/vlmrw_checker.sv
`include "variable_length_message_ring_writer_defines.svh"

module vlmrw_checker import vlmrw_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [2:0]        res_status,
  input logic              res_wr_valid,
  input logic [ADDR_W-1:0] res_wr_addr,
  input logic [DATA_W-1:0] res_wr_data,
  input logic              res_last
);

  `VLMRW_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_wr_data) && $stable(res_wr_addr) && $stable(res_status), "stalled result changed")
  `VLMRW_ASSERT_IMPL(a_err_no_write, res_valid && res_status != STATUS_OK, !res_wr_valid && res_last, "error result writes or is not last")
  `VLMRW_ASSERT_IMPL(a_word_aligned, res_valid && res_wr_valid, res_wr_addr[1:0] == 2'b00, "ring write not word aligned")
  `VLMRW_ASSERT_NEXT_ALWAYS(a_reset_idle, rst, !res_valid, "result valid after reset")

endmodule

bind variable_length_message_ring_writer vlmrw_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_status  (res.status),
  .res_wr_valid(res.wr_valid),
  .res_wr_addr (res.wr_addr),
  .res_wr_data (res.wr_data),
  .res_last    (res.last)
);
